### sv/bse_pkg.sv
`timescale 1ns / 1ps
// Package for the bit-vector store engine: command and state codes, memory request struct,
// and the word-mask, length and bit-search helpers. Depends on nothing.
package bse_pkg;

   localparam int WORD_BITS = 32;
   localparam int MAX_BITS  = 1024;
   localparam int NWORDS    = MAX_BITS / WORD_BITS;
   localparam int ADDR_W    = $clog2(NWORDS);
   localparam int BIT_W     = $clog2(WORD_BITS);
   localparam int COUNT_W   = 11;
   localparam int INDEX_W   = 10;
   localparam int HASH_ROT  = 5;

   localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(MAX_BITS);

   typedef logic [WORD_BITS-1:0] word_type;
   typedef logic [ADDR_W-1:0]    addr_type;
   typedef logic [BIT_W-1:0]     bitpos_type;
   typedef logic [COUNT_W-1:0]   count_type;

   typedef enum logic [3:0] {
      CMD_SET        = 4'd0,
      CMD_CLEAR      = 4'd1,
      CMD_TEST       = 4'd2,
      CMD_FIND_FIRST = 4'd3,
      CMD_FIND_LAST  = 4'd4,
      CMD_FILL_ZERO  = 4'd5,
      CMD_FILL_ONE   = 4'd6,
      CMD_AND_NOT    = 4'd7,
      CMD_OR         = 4'd8,
      CMD_COMPARE    = 4'd9,
      CMD_HASH       = 4'd10
   } cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SINGLE,
      ST_SCAN,
      ST_FILL
   } state_type;

   typedef struct packed {
      addr_type rd_addr;
      logic     wr_en;
      addr_type wr_addr;
      word_type wr_data;
   } ram_req_type;

   // Out-of-range lengths are clamped: zero acts as one, anything above the store acts as full.
   function automatic count_type eff_count(input count_type bit_count);
      count_type result;
      if (bit_count == '0) begin
         result = COUNT_W'(1);
      end else if (bit_count > COUNT_RESET) begin
         result = COUNT_RESET;
      end else begin
         result = bit_count;
      end
      return result;
   endfunction

   function automatic addr_type last_index(input count_type eff);
      count_type minus_one;
      minus_one = eff - COUNT_W'(1);
      return minus_one[ADDR_W+BIT_W-1:BIT_W];
   endfunction

   // The last active word only keeps the bits below the active length.
   function automatic word_type word_mask(input addr_type idx, input count_type eff);
      bitpos_type k;
      word_type   result;
      k = eff[BIT_W-1:0];
      if (idx == last_index(eff) && k != '0) begin
         result = ~(word_type'('1) << k);
      end else begin
         result = '1;
      end
      return result;
   endfunction

   function automatic bitpos_type lowest_bit(input word_type v);
      word_type   one_hot;
      bitpos_type pos;
      one_hot = v & (~v + word_type'(1));
      pos = '0;
      for (int i = 0; i < WORD_BITS; i++) begin
         for (int b = 0; b < BIT_W; b++) begin
            if (i[b]) begin
               pos[b] = pos[b] | one_hot[i];
            end
         end
      end
      return pos;
   endfunction

   function automatic word_type reverse_word(input word_type v);
      word_type r;
      for (int i = 0; i < WORD_BITS; i++) begin
         r[i] = v[WORD_BITS-1-i];
      end
      return r;
   endfunction

endpackage

### sv/bitset_store_engine.sv
`timescale 1ns / 1ps
// Top level of the bit-vector store engine: command sequencer, read-modify-write datapath,
// find, fill, compare and hash logic. Depends on bse_pkg and bse_word_ram.
//
//   Channel   Ports                          Transaction completes when
//   -------   -----------------------------  --------------------------------------
//   request   start, busy, req_*             start high and busy low at a clock edge
//   response  rsp_valid, rsp_*               rsp_valid high for one cycle
//   csr       csr_valid, csr_ready, csr_*    csr_valid and csr_ready both high
//
// Single-word commands (set, clear, test, and-not, or, compare, unused codes) read the
// word at acceptance; set, clear, and-not and or write it back in the next cycle unless
// out of range, and the strobe follows. Find, fill and hash walk the active words one per
// cycle; a find stops at its first hit. Reset is synchronous and active high: per-word
// valid bits clear the store, the length goes to full and the running match to one. The
// receiver cannot stall the response.
module bitset_store_engine (
   input  logic        clock,
   input  logic        reset,

   input  logic        start,
   output logic        busy,
   input  logic [3:0]  req_command,
   input  logic [9:0]  req_bit_index,
   input  logic [4:0]  req_word_index,
   input  logic [31:0] req_operand_word,
   input  logic        req_last_word,

   output logic        rsp_valid,
   output logic        rsp_status,
   output logic        rsp_bit_value,
   output logic        rsp_found,
   output logic [9:0]  rsp_position,
   output logic        rsp_equal,
   output logic [31:0] rsp_hash_value,

   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [10:0] csr_bit_count
);
   import bse_pkg::*;

   // Sequencer state and the transaction held while it is worked on.
   state_type  state_ff, state_in;
   cmd_type    cmd_ff;
   logic [INDEX_W-1:0] bit_index_ff;
   addr_type   addr_ff;
   word_type   operand_ff;
   logic       last_ff;
   logic       err_ff;
   addr_type   idx_ff, idx_in;
   word_type   hash_ff, hash_in;
   logic       match_ff;
   count_type  bit_count_ff;

   // Response registers.
   logic       rsp_valid_ff;
   logic       status_ff, status_in;
   logic       bit_value_ff, bit_value_in;
   logic       found_ff, found_in;
   logic [INDEX_W-1:0] position_ff, position_in;
   logic       equal_ff, equal_in;
   word_type   hash_value_ff;

   ram_req_type ram_req;
   word_type    rd_data;

   count_type  eff;
   addr_type   last_idx;
   logic       accept;
   cmd_type    req_cmd;
   logic       req_err;
   addr_type   req_addr;
   addr_type   start_idx;

   word_type   sel_bit;
   word_type   new_word;
   logic       single_write;
   logic       mismatch;
   logic       match_next;
   word_type   scan_word;
   logic       scan_hit;
   logic       scan_down;
   logic       is_find;
   logic       at_end;
   logic       scan_done;
   word_type   hash_next;
   word_type   hash_abs;
   logic       finish;

   bse_word_ram u_word_ram (
      .clock   (clock),
      .reset   (reset),
      .ram_req (ram_req),
      .rd_data (rd_data)
   );

   assign eff      = eff_count(bit_count_ff);
   assign last_idx = last_index(eff);

   assign busy      = (state_ff != ST_IDLE);
   assign accept    = start && !busy;
   assign csr_ready = !busy;

   // Decode of the incoming transaction. Bit commands address the word holding the bit;
   // scans start at one end of the active words, fills at word zero.
   always_comb begin
      req_cmd  = cmd_type'(req_command);
      req_err  = 1'b0;
      req_addr = req_word_index;
      case (req_cmd)
         CMD_SET, CMD_CLEAR, CMD_TEST: begin
            req_err  = ({1'b0, req_bit_index} >= eff);
            req_addr = req_bit_index[INDEX_W-1:BIT_W];
         end
         CMD_AND_NOT, CMD_OR, CMD_COMPARE: begin
            req_err = (req_word_index > last_idx);
         end
         default: begin
         end
      endcase
      case (req_cmd)
         CMD_FIND_FIRST, CMD_HASH, CMD_FILL_ZERO, CMD_FILL_ONE: start_idx = '0;
         CMD_FIND_LAST:                                         start_idx = last_idx;
         default:                                               start_idx = req_addr;
      endcase
   end

   // Datapath on the word that the memory returns.
   always_comb begin
      sel_bit = word_type'(1) << bit_index_ff[BIT_W-1:0];
      case (cmd_ff)
         CMD_SET:     new_word = rd_data | sel_bit;
         CMD_CLEAR:   new_word = rd_data & ~sel_bit;
         CMD_AND_NOT: new_word = rd_data & ~operand_ff;
         CMD_OR:      new_word = rd_data | operand_ff;
         default:     new_word = rd_data;
      endcase
      single_write = !err_ff && (cmd_ff inside {CMD_SET, CMD_CLEAR, CMD_AND_NOT, CMD_OR});

      // A compare beyond the active length is a mismatch; the last word compares its
      // active bits only.
      mismatch   = err_ff ||
                   (((rd_data ^ operand_ff) & word_mask(addr_ff, eff)) != '0);
      match_next = match_ff && !mismatch;

      scan_word = rd_data & word_mask(idx_ff, eff);
      scan_hit  = (scan_word != '0);
      scan_down = (cmd_ff == CMD_FIND_LAST);
      is_find   = (cmd_ff == CMD_FIND_FIRST) || (cmd_ff == CMD_FIND_LAST);
      at_end    = scan_down ? (idx_ff == '0) : (idx_ff == last_idx);
      scan_done = (is_find && scan_hit) || at_end;

      hash_next = {hash_ff[WORD_BITS-HASH_ROT-1:0], hash_ff[WORD_BITS-1:WORD_BITS-HASH_ROT]}
                  ^ rd_data;
      // Two's complement magnitude; the most negative value maps onto itself.
      hash_abs  = hash_next[WORD_BITS-1] ? (~hash_next + word_type'(1)) : hash_next;
   end

   // Next-state logic of the sequencer.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_cmd)
                  CMD_FIND_FIRST, CMD_FIND_LAST, CMD_HASH: state_in = ST_SCAN;
                  CMD_FILL_ZERO, CMD_FILL_ONE:             state_in = ST_FILL;
                  default:                                 state_in = ST_SINGLE;
               endcase
            end
         end
         ST_SINGLE: state_in = ST_IDLE;
         ST_SCAN: begin
            if (scan_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_FILL: begin
            if (idx_ff == last_idx) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Sequencer outputs: memory requests, walk index and the finish strobe.
   always_comb begin
      ram_req = '0;
      idx_in  = idx_ff;
      finish  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            ram_req.rd_addr = start_idx;
            if (accept) begin
               idx_in = start_idx;
            end
         end
         ST_SINGLE: begin
            ram_req.wr_en   = single_write;
            ram_req.wr_addr = addr_ff;
            ram_req.wr_data = new_word;
            finish          = 1'b1;
         end
         ST_SCAN: begin
            // The next word is read while the current one is examined.
            idx_in          = scan_down ? (idx_ff - addr_type'(1)) : (idx_ff + addr_type'(1));
            ram_req.rd_addr = idx_in;
            finish          = scan_done;
         end
         ST_FILL: begin
            ram_req.wr_en   = 1'b1;
            ram_req.wr_addr = idx_ff;
            ram_req.wr_data = (cmd_ff == CMD_FILL_ONE) ? word_mask(idx_ff, eff) : '0;
            idx_in          = idx_ff + addr_type'(1);
            finish          = (idx_ff == last_idx);
         end
         default: begin
         end
      endcase
   end

   // Hash accumulator is seeded with the effective length.
   always_comb begin
      hash_in = hash_ff;
      if (accept) begin
         hash_in = word_type'(eff);
      end else if (state_ff == ST_SCAN) begin
         hash_in = hash_next;
      end
   end

   // Response fields: zero where not of the command; equal holds the running match.
   always_comb begin
      status_in    = (state_ff == ST_SINGLE) && err_ff;
      bit_value_in = (state_ff == ST_SINGLE) && (cmd_ff == CMD_TEST) && !err_ff &&
                     rd_data[bit_index_ff[BIT_W-1:0]];
      found_in     = (state_ff == ST_SCAN) && is_find && scan_hit;
      position_in  = '0;
      if (found_in) begin
         if (scan_down) begin
            position_in = {idx_ff, ~lowest_bit(reverse_word(scan_word))};
         end else begin
            position_in = {idx_ff, lowest_bit(scan_word)};
         end
      end
      equal_in = ((state_ff == ST_SINGLE) && (cmd_ff == CMD_COMPARE)) ? match_next : match_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         match_ff     <= 1'b1;
         bit_count_ff <= COUNT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= finish;
         if (csr_valid && csr_ready) begin
            bit_count_ff <= csr_bit_count;
         end
         // The running match closes and restarts at the final word of a compare sequence.
         if (state_ff == ST_SINGLE && cmd_ff == CMD_COMPARE) begin
            match_ff <= last_ff ? 1'b1 : match_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      idx_ff  <= idx_in;
      hash_ff <= hash_in;
      if (accept) begin
         cmd_ff       <= req_cmd;
         bit_index_ff <= req_bit_index;
         addr_ff      <= req_addr;
         operand_ff   <= req_operand_word;
         last_ff      <= req_last_word;
         err_ff       <= req_err;
      end
      if (finish) begin
         status_ff     <= status_in;
         bit_value_ff  <= bit_value_in;
         found_ff      <= found_in;
         position_ff   <= position_in;
         equal_ff      <= equal_in;
         hash_value_ff <= ((state_ff == ST_SCAN) && (cmd_ff == CMD_HASH)) ? hash_abs : '0;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = status_ff;
   assign rsp_bit_value  = bit_value_ff;
   assign rsp_found      = found_ff;
   assign rsp_position   = position_ff;
   assign rsp_equal      = equal_ff;
   assign rsp_hash_value = hash_value_ff;

endmodule

### sv/bse_word_ram.sv
`timescale 1ns / 1ps
// Word store of the bit-vector engine: one write and one registered read per cycle.
// Depends on bse_pkg. Per-word valid bits make never-written words read as zero.
module bse_word_ram (
   input  logic                  clock,
   input  logic                  reset,
   input  bse_pkg::ram_req_type  ram_req,
   output bse_pkg::word_type     rd_data
);
   import bse_pkg::*;

   word_type          word_mem [NWORDS];
   logic [NWORDS-1:0] valid_ff;
   word_type          rd_data_ff;
   logic              rd_valid_ff;

   always_ff @(posedge clock) begin
      if (ram_req.wr_en) begin
         word_mem[ram_req.wr_addr] <= ram_req.wr_data;
      end
      rd_data_ff <= word_mem[ram_req.rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (ram_req.wr_en) begin
            valid_ff[ram_req.wr_addr] <= 1'b1;
         end
         rd_valid_ff <= valid_ff[ram_req.rd_addr];
      end
   end

   assign rd_data = rd_valid_ff ? rd_data_ff : '0;

endmodule
